### sv/fsc_pkg.sv
// Shared types, opcode codes and saturation helpers for the frustum sphere culler.
`timescale 1ns / 1ps
package fsc_pkg;

    typedef logic [1:0] opcode_t;

    localparam opcode_t OP_LOAD    = 2'd0;
    localparam opcode_t OP_REBUILD = 2'd1;
    localparam opcode_t OP_TEST    = 2'd2;

    localparam int COEF_W = 32;
    localparam int LEN_W  = 32;

    // Clamp a 33-bit signed sum to signed 32 bits.
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Magnitude of a signed 32-bit value, as unsigned 32 bits.
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? (32'd0 - 32'(v)) : 32'(v);
        return r;
    endfunction

endpackage

### sv/fsc_sqrt.sv
// Iterative 64-bit integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module fsc_sqrt
    import fsc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [63:0]       radicand,
    output logic              done,
    output logic [LEN_W-1:0]  root
);

    logic [63:0] s_reg, s_next;
    logic [63:0] res_reg, res_next;
    logic [4:0]  i_reg, i_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] bit_val;
    logic [63:0] trial;

    assign bit_val = 64'd1 << {i_reg, 1'b0};
    assign trial   = res_reg + bit_val;

    // One step of the bitwise root
    always_comb begin
        s_next    = s_reg;
        res_next  = res_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            s_next    = radicand;
            res_next  = '0;
            i_next    = 5'd31;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (s_reg >= trial) begin
                s_next   = s_reg - trial;
                res_next = (res_reg >> 1) + bit_val;
            end else begin
                res_next = res_reg >> 1;
            end
            if (i_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                i_next = i_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        s_reg   <= s_next;
        res_reg <= res_next;
        i_reg   <= i_next;
    end

    assign done = done_reg;
    assign root = res_reg[LEN_W-1:0];

endmodule

### sv/fsc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module fsc_div
    import fsc_pkg::*;
#(
    parameter int NUM_W = 48
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [NUM_W-1:0]  numer,
    input  logic [LEN_W-1:0]  denom,
    output logic              done,
    output logic [NUM_W-1:0]  quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] work_reg, work_next;
    logic [LEN_W:0]   rem_reg, rem_next;
    logic [LEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [LEN_W:0]   shifted;

    assign shifted = {rem_reg[LEN_W-1:0], work_reg[NUM_W-1]};

    // Shift one numerator bit into the remainder, subtract when it fits
    always_comb begin
        work_next = work_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            work_next = numer;
            rem_next  = '0;
            den_next  = denom;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, den_reg}) begin
                rem_next  = shifted - {1'b0, den_reg};
                work_next = {work_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next  = shifted;
                work_next = {work_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        work_reg <= work_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        cnt_reg  <= cnt_next;
    end

    assign done = done_reg;
    assign quot = work_reg;

endmodule

### sv/frustum_sphere_culling_core.sv
// Top level: matrix and plane storage, shared multiplier and sequencer.
`timescale 1ns / 1ps
// Frustum sphere culler.
// Input stream (s_axis_*): one request per handshake; tuser carries the opcode
// (load matrix element, rebuild planes, test sphere), tdata the operands.
// Output stream (m_axis_*): one request per sphere test, tdata[0] = visible.
// Loads finish in the accept cycle. A sphere test runs through one shared
// 33x33 multiplier, a multiply step and an accumulate step per product, with
// an early exit on the first plane that culls, then an output step.
// A rebuild goes per plane through element reads, the squared norm, a square
// root and 4 divides, one per coefficient; a plane with zero norm skips root
// and divides and keeps its raw coefficients.
// s_axis_tready is high only while the sequencer is idle; one request is in
// work at a time. A finished result waits in the output register while the
// receiver stalls, and the next request is taken meanwhile; a second test
// then holds in its output step until the register drains.
// Reset clears matrix, planes and handshake state, so every sphere reads
// visible until the first rebuild.
module frustum_sphere_culling_core
    import fsc_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // matrix_row, matrix_col, element_value, center_x, center_y, center_z,
    // sphere_radius, zero pad
    input  logic [167:0] s_axis_tdata,
    // opcode
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // visible, zero pad
    output logic [7:0]   m_axis_tdata
);

    localparam int NUM_W = COEF_W + FRAC_BITS;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_TS_D  = 4'd1;
    localparam logic [3:0] ST_TS_M  = 4'd2;
    localparam logic [3:0] ST_TS_A  = 4'd3;
    localparam logic [3:0] ST_TS_C  = 4'd4;
    localparam logic [3:0] ST_TS_O  = 4'd5;
    localparam logic [3:0] ST_RB_A  = 4'd6;
    localparam logic [3:0] ST_RB_B  = 4'd7;
    localparam logic [3:0] ST_SQ_M  = 4'd8;
    localparam logic [3:0] ST_SQ_A  = 4'd9;
    localparam logic [3:0] ST_SQ_C  = 4'd10;
    localparam logic [3:0] ST_SQ_W  = 4'd11;
    localparam logic [3:0] ST_DV_S  = 4'd12;
    localparam logic [3:0] ST_DV_W  = 4'd13;
    localparam logic [3:0] ST_WR    = 4'd14;

    // Request fields
    opcode_t            in_op;
    logic [1:0]         in_row, in_col;
    logic signed [31:0] in_elem;
    logic signed [31:0] in_cx, in_cy, in_cz;
    logic [30:0]        in_rad;
    logic               accept;

    assign in_op   = s_axis_tuser;
    assign in_row  = s_axis_tdata[1:0];
    assign in_col  = s_axis_tdata[3:2];
    assign in_elem = s_axis_tdata[35:4];
    assign in_cx   = s_axis_tdata[67:36];
    assign in_cy   = s_axis_tdata[99:68];
    assign in_cz   = s_axis_tdata[131:100];
    assign in_rad  = s_axis_tdata[162:132];

    logic [3:0]         state_reg;
    logic [2:0]         p_reg;
    logic [1:0]         k_reg;
    logic signed [31:0] mat_reg [16];
    logic signed [31:0] plane_reg [24];
    logic signed [31:0] raw_reg [4];
    logic signed [31:0] ctr_reg [3];
    logic [30:0]        rad_reg;
    logic signed [31:0] a_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic [63:0]        s_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               zero_reg;
    logic               vis_reg;
    logic               m_vis_reg;
    logic               m_valid_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Single read port on the plane and matrix stores
    logic [4:0]         pl_idx;
    logic [3:0]         mat_idx;
    logic signed [31:0] pl_rd, mat_rd;

    assign pl_idx  = (state_reg == ST_TS_D) ? {p_reg, 2'd3} : {p_reg, k_reg};
    assign mat_idx = (state_reg == ST_RB_A) ? {k_reg, 2'd3} : {k_reg, p_reg[2:1]};
    assign pl_rd   = plane_reg[pl_idx];
    assign mat_rd  = mat_reg[mat_idx];

    // Shared multiplier operand select
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [31:0]        raw_mag;

    assign raw_mag = mag32(raw_reg[k_reg]);

    always_comb begin
        if (state_reg == ST_SQ_M) begin
            mul_a = {1'b0, raw_mag};
            mul_b = {1'b0, raw_mag};
        end else begin
            mul_a = {pl_rd[31], pl_rd};
            mul_b = {ctr_reg[k_reg][31], ctr_reg[k_reg]};
        end
    end
    assign mul_p = mul_a * mul_b;

    // Raw plane coefficient: column 3 plus or minus the selected column
    logic signed [32:0] raw_sum;
    assign raw_sum = p_reg[0] ? ({a_reg[31], a_reg} - {mat_rd[31], mat_rd})
                              : ({a_reg[31], a_reg} + {mat_rd[31], mat_rd});

    // Distance compare against minus radius
    logic signed [63:0] neg_rad;
    assign neg_rad = 64'sd0 - $signed({33'd0, rad_reg});

    // Root and divide units
    logic             sq_start, sq_done;
    logic [LEN_W-1:0] sq_root;
    logic             dv_start, dv_done;
    logic [NUM_W-1:0] dv_quot;
    logic [NUM_W-1:0] dv_numer;

    assign sq_start = (state_reg == ST_SQ_C) && (s_reg != 64'd0);
    assign dv_start = (state_reg == ST_DV_S);
    assign dv_numer = {raw_mag, {FRAC_BITS{1'b0}}};

    fsc_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (s_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    fsc_div #(.NUM_W(NUM_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dv_start),
        .numer   (dv_numer),
        .denom   (len_reg),
        .done    (dv_done),
        .quot    (dv_quot)
    );

    // Saturate the quotient with the coefficient's sign
    logic               q_big;
    logic signed [31:0] q_sat;
    logic signed [31:0] wr_val;

    assign q_big = |dv_quot[NUM_W-1:31];
    always_comb begin
        if (raw_reg[k_reg][31]) begin
            q_sat = q_big ? 32'sh8000_0000 : $signed(32'd0 - dv_quot[31:0]);
        end else begin
            q_sat = (q_big || dv_quot[31]) ? 32'sh7fff_ffff : $signed(dv_quot[31:0]);
        end
    end
    assign wr_val = zero_reg ? raw_reg[k_reg] : q_sat;

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            p_reg       <= '0;
            k_reg       <= '0;
            for (int i = 0; i < 16; i++) begin
                mat_reg[i] <= '0;
            end
            for (int i = 0; i < 24; i++) begin
                plane_reg[i] <= '0;
            end
        end else begin
            // Output drains; the output step reloads it itself
            if (m_valid_reg && m_axis_tready && (state_reg != ST_TS_O)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        p_reg <= '0;
                        k_reg <= '0;
                        case (in_op)
                            OP_LOAD: begin
                                mat_reg[{in_row, in_col}] <= in_elem;
                            end
                            OP_REBUILD: begin
                                state_reg <= ST_RB_A;
                            end
                            OP_TEST: begin
                                ctr_reg[0] <= in_cx;
                                ctr_reg[1] <= in_cy;
                                ctr_reg[2] <= in_cz;
                                rad_reg    <= in_rad;
                                state_reg  <= ST_TS_D;
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                // Sphere test
                ST_TS_D: begin
                    acc_reg   <= 64'(pl_rd);
                    k_reg     <= '0;
                    state_reg <= ST_TS_M;
                end
                ST_TS_M: begin
                    prod_reg  <= mul_p[63:0];
                    state_reg <= ST_TS_A;
                end
                ST_TS_A: begin
                    acc_reg <= acc_reg + (prod_reg >>> FRAC_BITS);
                    if (k_reg == 2'd2) begin
                        state_reg <= ST_TS_C;
                    end else begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= ST_TS_M;
                    end
                end
                ST_TS_C: begin
                    if (acc_reg < neg_rad) begin
                        vis_reg   <= 1'b0;
                        state_reg <= ST_TS_O;
                    end else if (p_reg == 3'd5) begin
                        vis_reg   <= 1'b1;
                        state_reg <= ST_TS_O;
                    end else begin
                        p_reg     <= p_reg + 3'd1;
                        state_reg <= ST_TS_D;
                    end
                end
                ST_TS_O: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_valid_reg <= 1'b1;
                        m_vis_reg   <= vis_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                // Plane rebuild: raw coefficients
                ST_RB_A: begin
                    a_reg     <= mat_rd;
                    state_reg <= ST_RB_B;
                end
                ST_RB_B: begin
                    raw_reg[k_reg] <= sat33(raw_sum);
                    k_reg          <= k_reg + 2'd1;
                    if (k_reg == 2'd3) begin
                        s_reg     <= '0;
                        state_reg <= ST_SQ_M;
                    end else begin
                        state_reg <= ST_RB_A;
                    end
                end
                // Squared normal length
                ST_SQ_M: begin
                    prod_reg  <= mul_p[63:0];
                    state_reg <= ST_SQ_A;
                end
                ST_SQ_A: begin
                    s_reg <= s_reg + prod_reg;
                    if (k_reg == 2'd2) begin
                        k_reg     <= '0;
                        state_reg <= ST_SQ_C;
                    end else begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= ST_SQ_M;
                    end
                end
                ST_SQ_C: begin
                    zero_reg  <= (s_reg == 64'd0);
                    state_reg <= (s_reg == 64'd0) ? ST_WR : ST_SQ_W;
                end
                ST_SQ_W: begin
                    if (sq_done) begin
                        len_reg   <= sq_root;
                        state_reg <= ST_DV_S;
                    end
                end
                // Normalize each coefficient
                ST_DV_S: begin
                    state_reg <= ST_DV_W;
                end
                ST_DV_W: begin
                    if (dv_done) begin
                        state_reg <= ST_WR;
                    end
                end
                ST_WR: begin
                    plane_reg[{p_reg, k_reg}] <= wr_val;
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == 2'd3) begin
                        if (p_reg == 3'd5) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            p_reg     <= p_reg + 3'd1;
                            state_reg <= ST_RB_A;
                        end
                    end else begin
                        state_reg <= zero_reg ? ST_WR : ST_DV_S;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, m_vis_reg};

    // Root never sees a zero radicand, divide never a zero divisor
    a_sqrt_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_start |-> (s_reg != 64'd0))
        else $error("square root started on zero norm");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_start |-> (len_reg != '0))
        else $error("divide started with zero length");

    a_test_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (in_op == OP_TEST)) |=> (state_reg == ST_TS_D))
        else $error("sphere test request not started");

    a_out_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TS_O && m_valid_reg && !m_axis_tready) |=> (state_reg == ST_TS_O))
        else $error("result overwrote a pending output");

endmodule
